FILE: rtl/core/rc_pkg.sv
// Shared constants and types for the rank compression block.
package rc_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned RANK_W        = 6;
  localparam int unsigned OUT_TDATA_W   = 8;
  localparam int unsigned MAX_ITEMS_DEF = 64;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              last_rank;
    logic              overflowed;
  } rc_result_t;

endpackage

FILE: rtl/core/rank_compression.sv
// Rank compression: loads a set of signed values, then streams each value's rank in arrival order.
// Values are stored in an arrival-order RAM and insertion-sorted into a second RAM, one
// element moved per cycle through its single read and write port: a value holds
// s_axis_tready_o low after it is taken while it is shifted into place among those already held.
// When the value flagged tlast arrives, each stored value is read back and the sorted RAM is
// scanned from the bottom to its first equal entry, whose index is the rank. Up to
// MAX_ITEMS values are held; later ones in the same set are dropped and every result of that
// set carries tuser = 1. A rank waits in an output register, so the next set may load meanwhile.
module rank_compression import rc_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [DATA_W-1:0]      s_axis_tdata_i,  // [31:0] value
  input  logic                   s_axis_tlast_i,  // last_item
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // [5:0] rank, [7:6] zero
  output logic                   m_axis_tlast_o,  // last_rank
  output logic                   m_axis_tuser_o   // overflowed
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PLACE,
    S_ORIG,
    S_KEY,
    S_SCAN
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic              ovf_q, ovf_d;
  logic              last_q, last_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [AW-1:0]     k_q, k_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] key_q, key_d;
  rc_result_t        res_q, res_d;
  logic              ovalid_q, ovalid_d;

  logic              accept, slot_free, out_load, greater, match, k_last;
  logic              s_we, s_re, o_we, o_re;
  logic [AW-1:0]     s_waddr, s_raddr;
  logic [DATA_W-1:0] s_wdata, s_rdata, o_rdata;

  rc_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_orig (
    .clk_i   (clk_i),
    .we_i    (o_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (s_axis_tdata_i),
    .re_i    (o_re),
    .raddr_i (k_q),
    .rdata_o (o_rdata)
  );

  rc_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_sorted (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free = !ovalid_q || m_axis_tready_i;
  assign greater   = $signed(s_rdata) > $signed(val_q);
  assign match     = (s_rdata == key_q);
  assign k_last    = ((CW'(k_q) + CW'(1)) == count_q);
  assign o_we      = accept && (count_q < CW'(MAX_ITEMS));
  assign o_re      = (state_q == S_ORIG);
  assign out_load  = (state_q == S_SCAN) && match && slot_free;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    last_d   = last_q;
    pos_d    = pos_q;
    idx_d    = idx_q;
    k_d      = k_q;
    val_d    = val_q;
    key_d    = key_q;
    res_d    = res_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    s_we     = 1'b0;
    s_re     = 1'b0;
    s_waddr  = pos_q;
    s_wdata  = val_q;
    s_raddr  = pos_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          last_d = s_axis_tlast_i;
          val_d  = s_axis_tdata_i;
          k_d    = '0;
          if (o_we) begin
            count_d = count_q + CW'(1);
            pos_d   = count_q[AW-1:0];
            if (count_q == '0) begin
              s_we    = 1'b1;
              s_waddr = '0;
              s_wdata = s_axis_tdata_i;
              state_d = s_axis_tlast_i ? S_ORIG : S_IDLE;
            end else begin
              s_re    = 1'b1;
              s_raddr = count_q[AW-1:0] - AW'(1);
              state_d = S_SHIFT;
            end
          end else begin
            ovf_d   = 1'b1;
            state_d = s_axis_tlast_i ? S_ORIG : S_IDLE;
          end
        end
      end
      S_SHIFT: begin
        s_we = 1'b1;
        if (greater) begin
          s_wdata = s_rdata;
          pos_d   = pos_q - AW'(1);
          if (pos_q == AW'(1)) begin
            state_d = S_PLACE;
          end else begin
            s_re    = 1'b1;
            s_raddr = pos_q - AW'(2);
          end
        end else begin
          state_d = last_q ? S_ORIG : S_IDLE;
        end
      end
      S_PLACE: begin
        s_we    = 1'b1;
        state_d = last_q ? S_ORIG : S_IDLE;
      end
      S_ORIG: begin
        state_d = S_KEY;
      end
      S_KEY: begin
        key_d   = o_rdata;
        idx_d   = '0;
        s_re    = 1'b1;
        s_raddr = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (match) begin
          if (slot_free) begin
            ovalid_d       = 1'b1;
            res_d.rank     = RANK_W'(idx_q);
            res_d.last_rank = k_last;
            res_d.overflowed = ovf_q;
            if (k_last) begin
              count_d = '0;
              ovf_d   = 1'b0;
              state_d = S_IDLE;
            end else begin
              k_d     = k_q + AW'(1);
              state_d = S_ORIG;
            end
          end
        end else begin
          idx_d   = idx_q + AW'(1);
          s_re    = 1'b1;
          s_raddr = idx_q + AW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      last_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      last_q   <= last_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    idx_q <= idx_d;
    k_q   <= k_d;
    val_q <= val_d;
    key_q <= key_d;
    res_q <= res_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(res_q.rank);
  assign m_axis_tlast_o  = res_q.last_rank;
  assign m_axis_tuser_o  = res_q.overflowed;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ITEMS))
    else $error("item count beyond capacity");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == CW'(MAX_ITEMS)))
    else $error("overflow flagged with room left");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ((CW'(idx_q) < count_q) && (CW'(k_q) < count_q)))
    else $error("rank scan ran past the stored set");

  a_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !m_axis_tready_i) |=> ($stable(res_q) && ovalid_q))
    else $error("pending result overwritten");

  a_set_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && k_last) |=> (count_q == '0 && !ovf_q && state_q == S_IDLE))
    else $error("set not cleared after final rank");

endmodule

FILE: rtl/core/rc_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module rc_ram import rc_pkg::*; #(
  parameter int unsigned DEPTH = MAX_ITEMS_DEF,
  parameter int unsigned AW    = $clog2(MAX_ITEMS_DEF)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: bench/tb_rank_compression.sv
// Self-checking bench for rank_compression: directed and random value sets against a rank predictor.
`timescale 1ns / 1ps

module tb_rank_compression;
  import rc_pkg::*;

  localparam int unsigned CAP        = MAX_ITEMS_DEF;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS = 10;

  class rank_scoreboard;
    logic [DATA_W-1:0] set_values[$];
    logic [DATA_W-1:0] ordered_values[$];
    logic              set_dropped;
    rc_result_t        expected_ranks[$];
    int unsigned       errors;

    function new();
      set_dropped = 1'b0;
      errors      = 0;
    endfunction

    function logic [RANK_W-1:0] rank_of(logic [DATA_W-1:0] v);
      foreach (ordered_values[i]) begin
        if (ordered_values[i] == v) return RANK_W'(i);
      end
      return '0;
    endfunction

    function void load_value(logic [DATA_W-1:0] v, logic last);
      int         pos;
      rc_result_t r;
      if (set_values.size() < CAP) begin
        set_values.push_back(v);
        pos = ordered_values.size();
        while (pos > 0 && $signed(ordered_values[pos-1]) > $signed(v)) pos--;
        ordered_values.insert(pos, v);
      end else begin
        set_dropped = 1'b1;
      end
      if (last) begin
        foreach (set_values[k]) begin
          r.rank       = rank_of(set_values[k]);
          r.last_rank  = (k == set_values.size() - 1);
          r.overflowed = set_dropped;
          expected_ranks.push_back(r);
        end
        set_values.delete();
        ordered_values.delete();
        set_dropped = 1'b0;
      end
    endfunction

    function void check_rank(rc_result_t got);
      rc_result_t want;
      if (expected_ranks.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: rank %0d last %0b ovf %0b",
                   got.rank, got.last_rank, got.overflowed);
        return;
      end
      want = expected_ranks.pop_front();
      if (got.rank !== want.rank || got.last_rank !== want.last_rank ||
          got.overflowed !== want.overflowed) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch: expected rank %0d last %0b ovf %0b, got rank %0d last %0b ovf %0b",
                   want.rank, want.last_rank, want.overflowed,
                   got.rank, got.last_rank, got.overflowed);
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [DATA_W-1:0]      s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;

  rank_scoreboard sb;
  int unsigned    src_idle_pct;
  int unsigned    sink_idle_pct;
  int unsigned    values_sent;
  int unsigned    quiet_cycles;

  rank_compression #(.MAX_ITEMS(CAP)) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // request monitors and no-progress watchdog
  always @(posedge clk_i) begin
    rc_result_t got;
    if (rst_ni) begin
      if (s_tvalid && s_tready) sb.load_value(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        got.rank       = m_tdata[RANK_W-1:0];
        got.last_rank  = m_tlast;
        got.overflowed = m_tuser;
        sb.check_rank(got);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("tb_rank_compression NOT OK");
          $finish;
        end
      end
    end
  end

  task automatic send_value(logic [DATA_W-1:0] v, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    values_sent++;
  endtask

  function automatic logic [DATA_W-1:0] pick_value(int unsigned flavor);
    case (flavor)
      0: return $urandom;
      1: return DATA_W'($signed($urandom_range(0, 7)) - 4);
      default: begin
        case ($urandom_range(4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          3: return 32'hffff_ffff;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic send_set(int unsigned count);
    int unsigned flavor;
    flavor = $urandom_range(2);
    for (int unsigned i = 0; i < count; i++)
      send_value(pick_value(flavor), i == count - 1);
  endtask

  function automatic int unsigned pick_set_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(1, 12);
    if (roll < 92) return $urandom_range(13, CAP);
    return $urandom_range(CAP, CAP + 4);
  endfunction

  task automatic run_phase(int unsigned src_pct, int unsigned sink_pct, int unsigned idx,
                           int unsigned goal);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    // a set of CAP + idx values first (full at idx 0, past capacity after), then random-size sets
    send_set(CAP + idx);
    while (values_sent < goal) send_set(pick_set_size());
  endtask

  initial begin
    sb            = new();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    values_sent   = 0;
    quiet_cycles  = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-value set
    send_value(32'h0000_0000, 1'b1);
    // signed extremes around zero
    send_value(32'h7fff_ffff, 1'b0);
    send_value(32'h8000_0000, 1'b0);
    send_value(32'hffff_ffff, 1'b0);
    send_value(32'h0000_0000, 1'b0);
    send_value(32'h0000_0001, 1'b1);
    // duplicates share the lowest rank
    send_value(32'd5, 1'b0);
    send_value(-32'sd3, 1'b0);
    send_value(32'd5, 1'b0);
    send_value(-32'sd3, 1'b0);
    send_value(32'd5, 1'b0);
    send_value(32'd7, 1'b1);
    // all equal
    send_value(32'h8000_0000, 1'b0);
    send_value(32'h8000_0000, 1'b0);
    send_value(32'h8000_0000, 1'b1);
    // descending
    send_value(32'd3, 1'b0);
    send_value(32'd2, 1'b0);
    send_value(32'd1, 1'b0);
    send_value(32'd0, 1'b1);

    run_phase(28, 87, 0, 180);
    run_phase(87, 28, 1, 340);
    run_phase(0, 0, 2, 500);
    s_tvalid <= 1'b0;
    // let the monitor book the final request first
    @(posedge clk_i);

    while (sb.expected_ranks.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_ranks.size() == 0) begin
      $display("tb_rank_compression OK");
    end else begin
      $display("tb_rank_compression NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/rc_pkg.sv
rtl/core/rc_ram.sv
rtl/core/rank_compression.sv
bench/tb_rank_compression.sv
